[rtl/pdm_pkg.sv]
// ----------------------------------------------------------------------------
// pdm_pkg: shared definitions for the PPS drift monitor
// Field widths, register indexes, reset values and the cell control bundle.
// ----------------------------------------------------------------------------
package pdm_pkg;

    // Field widths
    localparam int CAPT_W   = 16;
    localparam int WINDOW_W = 17;
    localparam int DIFF_W   = 17;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default history length in pulses
    localparam int DEFAULT_HISTORY_DEPTH = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_LIMIT   = 2'd2;

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_LIMIT_RST = 17'd100000;
    localparam logic                GATE_ENABLE_RST  = 1'b1;
    localparam logic [CAPT_W-1:0]   GATE_LIMIT_RST   = 16'd60000;

    // Control broadcast to every history cell
    typedef struct packed {
        logic              shift;
        logic              fill;
        logic [CAPT_W-1:0] capture;
    } pdm_cell_ctrl_t;

endpackage

[rtl/pdm_if.sv]
// ----------------------------------------------------------------------------
// pdm_if: handshake channels of the PPS drift monitor
// Capture input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pdm_sample_if import pdm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CAPT_W-1:0] capture_value;

    modport source (output valid, output capture_value, input ready);
    modport sink   (input valid, input capture_value, output ready);
endinterface

interface pdm_result_if import pdm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     gated_out;
    logic                     in_window;
    logic signed [DIFF_W-1:0] drift_diff;
    logic [WORD_W-1:0]        event_total;
    logic signed [WORD_W-1:0] diff_sum;

    modport source (output valid, output gated_out, output in_window, output drift_diff,
                    output event_total, output diff_sum, input ready);
    modport sink   (input valid, input gated_out, input in_window, input drift_diff,
                    input event_total, input diff_sum, output ready);
endinterface

interface pdm_cfg_if import pdm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pps_drift_monitor_top.sv]
// ----------------------------------------------------------------------------
// pps_drift_monitor_top: ten-pulse drift monitor for a 1PPS capture timer
//
// Channels: sample carries one captured timer value per pulse, result returns
// one item per capture (gate flag, window flag, difference, event count and
// running sum), cfg writes window_limit (0), gate_enable (1), gate_limit (2);
// other indexes are dropped. cfg is always ready.
// Output: a result is loaded into the output register when its capture
// transfers. Throughput: one capture per cycle while no result waits on
// result.ready; the step is one 18-bit subtract and compare plus a 32-bit
// add, and the history row of HISTORY_DEPTH cells shifts or refills with it.
// Reset: registers return to their defaults, counters and history clear;
// the block takes captures as soon as reset is released.
// Stall: while a result waits on result.ready, sample.ready drops; a new
// capture transfers in the same cycle that the waiting result leaves.
// ----------------------------------------------------------------------------
module pps_drift_monitor_top import pdm_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    pdm_cfg_if.sink       cfg,
    pdm_sample_if.sink    sample,
    pdm_result_if.source  result
);

    // Configuration registers
    logic [WINDOW_W-1:0] window_limit_reg;
    logic                gate_enable_reg;
    logic [CAPT_W-1:0]   gate_limit_reg;

    // Counters
    logic [WORD_W-1:0] count_reg;
    logic [WORD_W-1:0] count_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;

    // Output register
    logic                     res_valid_reg;
    logic                     res_gated_reg;
    logic                     res_window_reg;
    logic signed [DIFF_W-1:0] res_diff_reg;
    logic [WORD_W-1:0]        res_count_reg;
    logic [WORD_W-1:0]        res_sum_reg;

    logic                       take;
    logic                       gated;
    logic [CAPT_W-1:0]          oldest;
    logic signed [DIFF_W:0]     diff_wide;
    logic signed [DIFF_W:0]     diff_neg;
    logic signed [DIFF_W:0]     lim_wide;
    logic                       accept;
    logic                       fill;
    pdm_cell_ctrl_t             cell_ctrl;

    // Take config writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= WINDOW_LIMIT_RST;
            gate_enable_reg  <= GATE_ENABLE_RST;
            gate_limit_reg   <= GATE_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_LIMIT: window_limit_reg <= cfg.data[WINDOW_W-1:0];
                REG_GATE_ENABLE:  gate_enable_reg  <= cfg.data[0];
                REG_GATE_LIMIT:   gate_limit_reg   <= cfg.data[CAPT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Accept a capture whenever the output register is free or draining
    assign sample.ready = !res_valid_reg || result.ready;
    assign take         = sample.valid && sample.ready;

    // Gate, difference and window test
    assign gated     = gate_enable_reg && (sample.capture_value >= gate_limit_reg);
    assign diff_wide = $signed({2'b00, sample.capture_value}) - $signed({2'b00, oldest});
    assign diff_neg  = -diff_wide;
    assign lim_wide  = $signed({1'b0, window_limit_reg});
    assign accept    = (diff_wide < lim_wide) && (diff_neg < lim_wide);

    // Advance counters on an accepted difference
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (!gated && accept)
        begin
            count_next = count_reg + WORD_W'(1);
            sum_next   = sum_reg + WORD_W'(diff_wide);
        end
    end

    // Refill the whole history while the count is at most one
    assign fill = (count_next <= WORD_W'(1));

    assign cell_ctrl.capture = sample.capture_value;
    assign cell_ctrl.fill    = take && !gated && fill;
    assign cell_ctrl.shift   = take && !gated && !fill;

    pdm_chain #(
        .DEPTH (HISTORY_DEPTH)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cell_ctrl),
        .oldest (oldest)
    );

    // Update counters on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Hold result valid until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_gated_reg  <= gated;
            res_window_reg <= !gated && accept;
            res_diff_reg   <= gated ? '0 : diff_wide[DIFF_W-1:0];
            res_count_reg  <= count_next;
            res_sum_reg    <= sum_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.gated_out   = res_gated_reg;
    assign result.in_window   = res_window_reg;
    assign result.drift_diff  = res_diff_reg;
    assign result.event_total = res_count_reg;
    assign result.diff_sum    = $signed(res_sum_reg);

`ifndef SYNTH
    // A transfer always leaves a result waiting in the next cycle
    a_take_gives_result : assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> res_valid_reg
    ) else $error("result missing after capture transfer");

    // A gated capture reports no window hit and a zero difference
    a_gated_clean : assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_gated_reg) |-> (!res_window_reg && (res_diff_reg == '0))
    ) else $error("gated result carries window data");

    // The event count moves by one exactly on an accepted, ungated difference
    a_count_step : assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> (count_reg == ($past(count_reg)
                  + WORD_W'($past(!gated && accept))))
    ) else $error("event count stepped wrongly");

    // Counters stay put between transfers
    a_count_hold : assert property (
        @(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(count_reg) && $stable(sum_reg))
    ) else $error("counters moved without a transfer");
`endif

endmodule

[rtl/pdm_cell.sv]
// ----------------------------------------------------------------------------
// pdm_cell: one history cell
// Holds one past capture; loads the fresh capture on fill, else takes the
// neighbor's value on shift.
// ----------------------------------------------------------------------------
module pdm_cell import pdm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  pdm_cell_ctrl_t    ctrl,
    input  logic [CAPT_W-1:0] prev_value,
    output logic [CAPT_W-1:0] value
);

    logic [CAPT_W-1:0] value_reg;
    logic [CAPT_W-1:0] value_next;

    // Pick fill, shift or hold
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.fill)
        begin
            value_next = ctrl.capture;
        end
        else if (ctrl.shift)
        begin
            value_next = prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[rtl/pdm_chain.sv]
// ----------------------------------------------------------------------------
// pdm_chain: row of history cells
// Fresh capture enters at the head; the tail holds the capture taken
// DEPTH ungated pulses ago.
// ----------------------------------------------------------------------------
module pdm_chain import pdm_pkg::*; #(
    parameter int DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pdm_cell_ctrl_t    ctrl,
    output logic [CAPT_W-1:0] oldest
);

    logic [CAPT_W-1:0] tap [DEPTH];

    // Build the row; each cell feeds its right neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            pdm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_value (ctrl.capture),
                .value      (tap[g])
            );
        end
        else
        begin : g_body
            pdm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_value (tap[g-1]),
                .value      (tap[g])
            );
        end
    end

    assign oldest = tap[DEPTH-1];

endmodule
